[rtl/bidirectional_address_pair_table_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bidirectional address pair table
// Shared property wrappers clocked on clk_i, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef BIDIRECTIONAL_ADDRESS_PAIR_TABLE_ASSERT_SVH
`define BIDIRECTIONAL_ADDRESS_PAIR_TABLE_ASSERT_SVH

// Checked only out of reset.
`define BAPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define BAPT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/bapt_pkg.sv]
// ----------------------------------------------------------------------------
// bapt_pkg
// Shared constants and types for the bidirectional address pair table.
// ----------------------------------------------------------------------------
`default_nettype none

package bapt_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CountW     = $clog2(TableDepth + 1);
  localparam int FillW      = 5;
  localparam int RemoveW    = 5;
  localparam int CmpW       = (CountW > RemoveW) ? CountW : RemoveW;
  localparam int AddrW      = 32;
  localparam int KindW      = 2;

  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [AddrW-1:0] src;
    logic [AddrW-1:0] dst;
  } pair_t;

  // broadcast to every cell
  typedef struct packed {
    logic              shift;
    logic [CountW-1:0] count;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/bapt_cell.sv]
// ----------------------------------------------------------------------------
// bapt_cell
// One table slot: holds a pair, passes it on to the next slot on insert,
// and matches it against the lookup key in both directions.
// ----------------------------------------------------------------------------
`default_nettype none

module bapt_cell (
  input  wire                          clk_i,
  input  wire  [bapt_pkg::IdxW-1:0]    idx_i,
  input  bapt_pkg::cell_ctrl_t         ctrl_i,
  input  bapt_pkg::pair_t              pair_i,
  input  wire  [bapt_pkg::AddrW-1:0]   key_a_i,
  input  wire  [bapt_pkg::AddrW-1:0]   key_b_i,
  output bapt_pkg::pair_t              pair_o,
  output logic                         hit_o
);

  bapt_pkg::pair_t pair_d, pair_q;
  logic            held;
  logic            fwd, rev;

  assign pair_d = ctrl_i.shift ? pair_i : pair_q;

  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
  end

  // slot holds a live entry when its position is below the fill
  assign held = (bapt_pkg::CountW'(idx_i) < ctrl_i.count);
  assign fwd  = (pair_q.src == key_a_i) && (pair_q.dst == key_b_i);
  assign rev  = (pair_q.src == key_b_i) && (pair_q.dst == key_a_i);

  assign hit_o  = held && (fwd || rev);
  assign pair_o = pair_q;

endmodule

`default_nettype wire

[rtl/bidirectional_address_pair_table.sv]
// ----------------------------------------------------------------------------
// bidirectional_address_pair_table
// Arrival-ordered table of address pairs with insert, two-way lookup and
// delete-oldest, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Takes one beat per cycle and answers each with one result beat in the cycle
// after it is taken; the only limit is the single output register, which
// accepts a new beat whenever it is empty or being drained that same cycle.
// The pairs live in a row of TableDepth cells. An insert loads the new pair
// into cell 0 and every cell hands its pair to its right-hand neighbor, so
// the oldest held pair sits at position fill-1. A delete only lowers the
// fill: cells at or above the fill drop out of lookups. A lookup compares
// the key against all held cells at once in both directions and ORs the
// hits. Inserts into a full table are refused and flagged. Kind code three
// is ignored and just reports the current fill. Cell contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bidirectional_address_pair_table (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire  [bapt_pkg::KindW-1:0]     kind_i,
  input  wire  [bapt_pkg::AddrW-1:0]     addr_a_i,
  input  wire  [bapt_pkg::AddrW-1:0]     addr_b_i,
  input  wire  [bapt_pkg::RemoveW-1:0]   remove_count_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic                           found_o,
  output logic                           dropped_o,
  output logic [bapt_pkg::FillW-1:0]     fill_o
);

  logic                          accept;
  logic                          full;
  logic [bapt_pkg::CountW-1:0]   count_d, count_q;
  logic [bapt_pkg::CmpW-1:0]     rc_ext, cnt_ext, del_n;
  logic                          found_d, found_q;
  logic                          dropped_d, dropped_q;
  logic                          out_valid_d, out_valid_q;
  logic                          do_shift;
  logic [bapt_pkg::TableDepth-1:0] hits;
  bapt_pkg::cell_ctrl_t          ctrl;
  bapt_pkg::pair_t               new_pair;
  bapt_pkg::pair_t               link [bapt_pkg::TableDepth];

  // output register drains or is empty -> room for the next beat
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full    = (count_q == bapt_pkg::CountW'(bapt_pkg::TableDepth));
  assign rc_ext  = bapt_pkg::CmpW'(remove_count_i);
  assign cnt_ext = bapt_pkg::CmpW'(count_q);
  assign del_n   = (rc_ext > cnt_ext) ? cnt_ext : rc_ext;   // clamp to fill

  always_comb begin
    count_d   = count_q;
    found_d   = 1'b0;
    dropped_d = 1'b0;
    do_shift  = 1'b0;
    case (bapt_pkg::kind_e'(kind_i))
      bapt_pkg::KIND_INSERT: begin
        if (full) begin
          dropped_d = 1'b1;
        end else begin
          do_shift = accept;
          count_d  = count_q + bapt_pkg::CountW'(1);
        end
      end
      bapt_pkg::KIND_LOOKUP: begin
        found_d = |hits;
      end
      bapt_pkg::KIND_DELETE: begin
        count_d = bapt_pkg::CountW'(cnt_ext - del_n);
      end
      default: begin
        count_d = count_q;   // unused code: no change
      end
    endcase
  end

  assign out_valid_d = accept ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // result payload, loaded with each accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      found_q   <= found_d;
      dropped_q <= dropped_d;
    end
  end

  assign ctrl.shift = do_shift;
  assign ctrl.count = count_q;

  assign new_pair.src = addr_a_i;
  assign new_pair.dst = addr_b_i;

  // cell 0 takes the new pair; each other cell takes its left neighbor
  for (genvar i = 0; i < bapt_pkg::TableDepth; i++) begin : g_cell
    bapt_pkg::pair_t cell_in;
    if (i == 0) begin : g_head
      assign cell_in = new_pair;
    end else begin : g_body
      assign cell_in = link[i-1];
    end

    bapt_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (bapt_pkg::IdxW'(i)),
      .ctrl_i  (ctrl),
      .pair_i  (cell_in),
      .key_a_i (addr_a_i),
      .key_b_i (addr_b_i),
      .pair_o  (link[i]),
      .hit_o   (hits[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign dropped_o   = dropped_q;
  assign fill_o      = bapt_pkg::FillW'(count_q);

endmodule

`default_nettype wire

[rtl/bapt_checker.sv]
// ----------------------------------------------------------------------------
// bapt_checker
// Port-level checks for the bidirectional address pair table.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bidirectional_address_pair_table_assert.svh"

module bapt_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            in_valid_i,
  input wire                            in_ready_o,
  input wire                            out_valid_o,
  input wire                            out_ready_i,
  input wire                            found_o,
  input wire                            dropped_o,
  input wire [bapt_pkg::FillW-1:0]      fill_o
);

  logic in_fire;
  logic out_stall;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;

  // stalled result holds
  `BAPT_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(found_o) && $stable(dropped_o) && $stable(fill_o), "result changed while stalled")

  // every taken beat shows a result next cycle
  `BAPT_ASSERT(a_result_follows, in_fire |=> out_valid_o, "taken beat produced no result")

  // an empty output stage never blocks the input
  `BAPT_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input blocked with no result pending")

  // a refused insert only happens on a full table
  `BAPT_ASSERT(a_drop_full, (out_valid_o && dropped_o) |-> (fill_o == bapt_pkg::FillW'(bapt_pkg::TableDepth)), "drop reported below full")

endmodule

bind bidirectional_address_pair_table bapt_checker u_bapt_checker (.*);

`default_nettype wire
